@@ sv/fstp_pkg.sv @@
// Shared types, constants and rule tables for the fuzzy self-tuning PID.
// No dependencies; used by every module of the block.
package fstp_pkg;

	localparam int SAMPLE_FRAC_BITS = 8;
	localparam int GAIN_FRAC_BITS   = 16;
	localparam int MU_BITS          = 16;
	localparam int NUM_SETS         = 7;

	localparam logic signed [31:0] KP_RESET = 32'sd65536;
	localparam logic signed [31:0] KI_RESET = 32'sd0;
	localparam logic signed [31:0] KD_RESET = 32'sd0;

	// configuration register indexes
	localparam logic [1:0] REG_KP_START = 2'd0;
	localparam logic [1:0] REG_KI_START = 2'd1;
	localparam logic [1:0] REG_KD_START = 2'd2;

	// defuzz units per real unit, and floor(2^32 / (units)) for the reciprocal divide
	localparam int          KP_UNITS    = 10;
	localparam int          KI_UNITS    = 50;
	localparam int          KD_UNITS    = 1;
	localparam int          RECIP_SHIFT = 32;
	localparam logic [31:0] RECIP_KP    = 32'd429496729;
	localparam logic [31:0] RECIP_KI    = 32'd85899345;

	// set code NS, where the Kd table uses its own slope
	localparam logic [2:0] CODE_NS = 3'd2;

	typedef struct packed {
		logic signed [15:0] setpoint;
		logic signed [15:0] feedback;
	} in_item_t;

	typedef struct packed {
		logic signed [39:0] drive_increment;
		logic signed [31:0] kp_now;
		logic signed [31:0] ki_now;
		logic signed [31:0] kd_now;
	} out_item_t;

	typedef struct packed {
		logic       cfg_we;
		logic       load;
		logic       fuzz;
		logic       scan;
		logic       defz;
		logic       corr;
		logic       mul;
		logic       fin;
		logic [2:0] step;
	} cmd_t;

	// rule tables, set code + 3, [e set][ec set]
	localparam logic [2:0] KP_TAB [7][7] = '{
		'{6,6,5,5,4,3,3}, '{6,6,5,4,4,3,3}, '{5,5,5,4,3,2,2}, '{5,5,4,3,2,1,1},
		'{4,4,3,2,2,1,1}, '{4,3,2,1,1,1,0}, '{3,3,1,1,1,0,0}};
	localparam logic [2:0] KI_TAB [7][7] = '{
		'{0,0,1,1,2,3,3}, '{0,0,1,2,2,3,3}, '{0,1,2,2,3,4,4}, '{1,1,2,3,4,5,5},
		'{1,2,3,4,4,5,6}, '{3,3,4,4,5,6,6}, '{3,3,4,5,5,6,6}};
	localparam logic [2:0] KD_TAB [7][7] = '{
		'{4,2,0,0,0,1,4}, '{4,2,0,1,1,2,3}, '{3,2,1,1,2,2,3}, '{3,2,2,2,2,2,3},
		'{3,3,3,3,3,3,3}, '{6,2,4,4,4,4,6}, '{6,5,5,5,4,4,6}};

	// set value = (A + B*mu)/2
	localparam logic signed [3:0] SET_A [7] = '{-2,-3,-2,0,2,3,2};
	localparam logic signed [3:0] SET_B [7] = '{-4,-1,0,0,0,1,4};

endpackage

@@ sv/fstp_ctrl.sv @@
// Sequencer for the fuzzy self-tuning PID: steps the datapath through
// fuzzify, rule scan, defuzz, gain update and PID multiply. Uses fstp_pkg.
module fstp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	output fstp_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_FUZZ, S_SCAN, S_DEFZ, S_CORR, S_MUL, S_FIN
	} state_t;

	state_t     state_q;
	logic [2:0] cnt_q;
	logic       out_valid_q;
	logic       fin_ok;

	assign fin_ok    = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		cmd        = '0;
		cmd.cfg_we = cfg_valid;
		cmd.step   = cnt_q;
		case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_FUZZ: cmd.fuzz = 1'b1;
			S_SCAN: cmd.scan = 1'b1;
			S_DEFZ: cmd.defz = 1'b1;
			S_CORR: cmd.corr = 1'b1;
			S_MUL:  cmd.mul  = 1'b1;
			S_FIN:  cmd.fin  = fin_ok;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && fin_ok)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_FUZZ;
				S_FUZZ: begin
					cnt_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (cnt_q == 3'(fstp_pkg::NUM_SETS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_DEFZ;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_DEFZ: state_q <= S_CORR;
				S_CORR: begin
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (cnt_q == 3'd2) begin
						cnt_q   <= '0;
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_FIN: begin
					if (fin_ok)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ sv/fstp_dp.sv @@
// Datapath of the fuzzy self-tuning PID: error history, memberships, rule
// scan, defuzz with reciprocal divide, gains and the PID accumulator. Uses fstp_pkg.
module fstp_dp #(
	parameter int SAMPLE_FRAC_BITS = fstp_pkg::SAMPLE_FRAC_BITS,
	parameter int GAIN_FRAC_BITS   = fstp_pkg::GAIN_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fstp_pkg::cmd_t      cmd,
	input  fstp_pkg::in_item_t  in_data,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output fstp_pkg::out_item_t out_data
);

	localparam int MU_BITS = fstp_pkg::MU_BITS;
	localparam int MUW     = MU_BITS + 1;
	localparam int YW      = 21 + GAIN_FRAC_BITS;
	localparam int XW      = YW - 17;
	localparam int PW      = XW + 32;
	localparam int ACCW    = 54;
	localparam logic [MUW-1:0] MU_ONE = MUW'(1) << MU_BITS;
	localparam logic signed [ACCW-1:0] RES_MAX = (ACCW'(1) <<< 39) - ACCW'(1);
	localparam logic signed [ACCW-1:0] RES_MIN = -(ACCW'(1) <<< 39);

	function automatic logic signed [19:0] pt(int u);
		return 20'(u * (1 << SAMPLE_FRAC_BITS));
	endfunction

	function automatic logic [MUW-1:0] ramp(logic signed [19:0] num, logic span2);
		logic [36:0] t;
		t = 37'(unsigned'(num)) << MU_BITS;
		return MUW'(t >> (SAMPLE_FRAC_BITS + int'(span2)));
	endfunction

	function automatic logic [MUW-1:0] tri_m(logic signed [19:0] x, int a, int b, int c);
		if (x <= pt(a)) return '0;
		if (x <= pt(b)) return ramp(x - pt(a), (b - a) == 2);
		if (x <= pt(c)) return ramp(pt(c) - x, (c - b) == 2);
		return '0;
	endfunction

	function automatic logic [MUW-1:0] memb(logic signed [19:0] x, int k);
		logic [MUW-1:0] r;
		case (k)
			0: r = (x <= pt(-3)) ? MU_ONE : ((x <= pt(-1)) ? ramp(pt(-1) - x, 1'b1) : '0);
			1: r = tri_m(x, -3, -2, 0);
			2: r = tri_m(x, -3, -1, 1);
			3: r = tri_m(x, -2, 0, 2);
			4: r = tri_m(x, -1, 1, 3);
			5: r = tri_m(x, 0, 2, 3);
			default: r = (x <= pt(1)) ? '0 : ((x < pt(3)) ? ramp(x - pt(1), 1'b1) : MU_ONE);
		endcase
		return r;
	endfunction

	// signed (A + B*mu) scaled by 2^16
	function automatic logic signed [20:0] set_val(logic [2:0] c, logic kd_ns,
			logic [MUW-1:0] mu);
		logic signed [20:0] av;
		logic signed [20:0] bv;
		logic signed [20:0] mv;
		av = 21'(fstp_pkg::SET_A[c]);
		bv = kd_ns ? 21'sd4 : 21'(fstp_pkg::SET_B[c]);
		mv = 21'(mu);
		return (av <<< MU_BITS) + bv * mv;
	endfunction

	// floor((|v|*2^GF + units*2^16) / 2^17)
	function automatic logic [XW-1:0] xval(logic [19:0] m, int units);
		logic [YW-1:0] y;
		y = (YW'(m) << GAIN_FRAC_BITS) + (YW'(units) << MU_BITS);
		return y[YW-1:17];
	endfunction

	function automatic logic [19:0] mag(logic signed [20:0] v);
		return v[20] ? 20'(-v) : 20'(v);
	endfunction

	function automatic logic signed [31:0] sat_add(logic signed [31:0] g, logic neg,
			logic [XW-1:0] q);
		logic signed [33:0] d;
		logic signed [33:0] s;
		d = signed'(34'(q));
		s = 34'(g) + (neg ? -d : d);
		if (s > 34'sh07FFFFFFF) return 32'sh7FFFFFFF;
		if (s < -34'sh080000000) return 32'sh80000000;
		return 32'(s);
	endfunction

	logic signed [16:0] e_q, e1_q, e2_q;
	logic signed [17:0] ec_q;
	logic [MUW-1:0]     me_q [7];
	logic [MUW-1:0]     mc_q [7];
	logic signed [17:0] best_q;
	logic [2:0]         bi_q, bj_q;
	logic signed [31:0] kp_q, ki_q, kd_q;
	logic               neg_p_q, neg_i_q, neg_d_q;
	logic [XW-1:0]      xp_q, xi_q, xd_q;
	logic [PW-1:0]      prodp_q, prodi_q;
	logic signed [ACCW-1:0] acc_q;
	fstp_pkg::out_item_t out_q;

	logic signed [16:0] e_n;
	logic signed [17:0] best_n;
	logic [2:0]         bi_n, bj_n;
	logic [MUW-1:0]     s_w;
	logic [2:0]         cp_w, ci_w, cd_w;
	logic signed [20:0] vp_w, vi_w, vd_w;
	logic [XW-1:0]      xp_w, xi_w;
	logic [XW-1:0]      q0p_w, q0i_w, rp_w, ri_w, qp_w, qi_w;
	logic signed [31:0] g_w;
	logic signed [18:0] op_w;
	logic signed [50:0] mprod_w;
	logic signed [ACCW-1:0] rnd_w, sh_w;

	assign e_n = 17'(in_data.setpoint) - 17'(in_data.feedback);

	// one row of the rule grid per cycle, first maximum wins
	always_comb begin
		best_n = best_q;
		bi_n   = bi_q;
		bj_n   = bj_q;
		s_w    = '0;
		for (int j = 0; j < 7; j++) begin
			s_w = (me_q[cmd.step] < mc_q[j]) ? me_q[cmd.step] : mc_q[j];
			if (signed'({1'b0, s_w}) > best_n) begin
				best_n = signed'({1'b0, s_w});
				bi_n   = cmd.step;
				bj_n   = 3'(j);
			end
		end
	end

	assign cp_w = fstp_pkg::KP_TAB[bi_q][bj_q];
	assign ci_w = fstp_pkg::KI_TAB[bi_q][bj_q];
	assign cd_w = fstp_pkg::KD_TAB[bi_q][bj_q];
	assign vp_w = set_val(cp_w, 1'b0, best_q[MUW-1:0]);
	assign vi_w = set_val(ci_w, 1'b0, best_q[MUW-1:0]);
	assign vd_w = set_val(cd_w, cd_w == fstp_pkg::CODE_NS, best_q[MUW-1:0]);
	assign xp_w = xval(mag(vp_w), fstp_pkg::KP_UNITS);
	assign xi_w = xval(mag(vi_w), fstp_pkg::KI_UNITS);

	// reciprocal estimate is low by at most one
	assign q0p_w = prodp_q[PW-1:fstp_pkg::RECIP_SHIFT];
	assign q0i_w = prodi_q[PW-1:fstp_pkg::RECIP_SHIFT];
	assign rp_w  = xp_q - XW'(q0p_w * fstp_pkg::KP_UNITS);
	assign ri_w  = xi_q - XW'(q0i_w * fstp_pkg::KI_UNITS);
	assign qp_w  = q0p_w + XW'(rp_w >= XW'(fstp_pkg::KP_UNITS));
	assign qi_w  = q0i_w + XW'(ri_w >= XW'(fstp_pkg::KI_UNITS));

	always_comb begin
		case (cmd.step[1:0])
			2'd0: begin
				g_w  = kp_q;
				op_w = 19'(e_q) - 19'(e1_q);
			end
			2'd1: begin
				g_w  = ki_q;
				op_w = 19'(e_q);
			end
			default: begin
				g_w  = kd_q;
				op_w = 19'(e_q) - (19'(e1_q) <<< 1) + 19'(e2_q);
			end
		endcase
	end

	assign mprod_w = 51'(g_w) * 51'(op_w);
	assign rnd_w   = acc_q + (ACCW'(1) <<< (SAMPLE_FRAC_BITS - 1));
	assign sh_w    = rnd_w >>> SAMPLE_FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q <= '0;
			e2_q <= '0;
			kp_q <= fstp_pkg::KP_RESET;
			ki_q <= fstp_pkg::KI_RESET;
			kd_q <= fstp_pkg::KD_RESET;
		end else begin
			if (cmd.cfg_we) begin
				case (cfg_index)
					fstp_pkg::REG_KP_START: kp_q <= signed'(cfg_data);
					fstp_pkg::REG_KI_START: ki_q <= signed'(cfg_data);
					fstp_pkg::REG_KD_START: kd_q <= signed'(cfg_data);
					default: ;
				endcase
			end else if (cmd.corr) begin
				kp_q <= sat_add(kp_q, neg_p_q, qp_w);
				ki_q <= sat_add(ki_q, neg_i_q, qi_w);
				kd_q <= sat_add(kd_q, neg_d_q, xd_q);
			end
			if (cmd.fin) begin
				e2_q <= e1_q;
				e1_q <= e_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e_q  <= e_n;
			ec_q <= 18'(e_n) - 18'(e1_q);
		end
		if (cmd.fuzz) begin
			for (int k = 0; k < 7; k++) begin
				me_q[k] <= memb(20'(e_q), k);
				mc_q[k] <= memb(20'(ec_q), k);
			end
			best_q <= -18'sd1;
			bi_q   <= '0;
			bj_q   <= '0;
		end
		if (cmd.scan) begin
			best_q <= best_n;
			bi_q   <= bi_n;
			bj_q   <= bj_n;
		end
		if (cmd.defz) begin
			neg_p_q <= vp_w[20];
			neg_i_q <= vi_w[20];
			neg_d_q <= vd_w[20];
			xp_q    <= xp_w;
			xi_q    <= xi_w;
			xd_q    <= xval(mag(vd_w), fstp_pkg::KD_UNITS);
			prodp_q <= PW'(xp_w) * PW'(fstp_pkg::RECIP_KP);
			prodi_q <= PW'(xi_w) * PW'(fstp_pkg::RECIP_KI);
		end
		if (cmd.mul)
			acc_q <= ((cmd.step[1:0] == 2'd0) ? '0 : acc_q) + ACCW'(mprod_w);
		if (cmd.fin) begin
			if (sh_w > RES_MAX)      out_q.drive_increment <= 40'(RES_MAX);
			else if (sh_w < RES_MIN) out_q.drive_increment <= 40'(RES_MIN);
			else                     out_q.drive_increment <= 40'(sh_w);
			out_q.kp_now <= kp_q;
			out_q.ki_now <= ki_q;
			out_q.kd_now <= kd_q;
		end
	end

	assign out_data = out_q;

endmodule

@@ sv/fuzzy_self_tuning_pid.sv @@
// Top level of the fuzzy self-tuning incremental PID controller.
// Instantiates fstp_ctrl and fstp_dp; types come from fstp_pkg.

// Each request runs these steps from acceptance to the next acceptance:
// fuzzify error and error change, scan the 7x7 rule grid a row per cycle,
// defuzzify, gain update (reciprocal divide), the shared gain-times-error
// multiplier, then round and register the result. A finished result waits
// in the output register while the next request is taken; the block only
// holds in the final state if that register is still full and out_stall is
// high. Configuration writes load the gain immediately and are meant for
// idle time; cfg_ready is always high and indexes past kd_start are ignored.
module fuzzy_self_tuning_pid #(
	parameter int SAMPLE_FRAC_BITS = fstp_pkg::SAMPLE_FRAC_BITS,
	parameter int GAIN_FRAC_BITS   = fstp_pkg::GAIN_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  fstp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output fstp_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	fstp_pkg::cmd_t cmd;

	fstp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	fstp_dp #(
		.SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS),
		.GAIN_FRAC_BITS   (GAIN_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

endmodule

@@ sv/fstp_check.sv @@
// Port-level checks for fuzzy_self_tuning_pid, bound to the top level.
// Uses fstp_pkg types only.
module fstp_check (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic                cfg_valid,
	input logic                cfg_ready,
	input fstp_pkg::out_item_t out_data
);

	// a request keeps the block busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after a request");

	// no new result rises while a taken request is in its fuzzify step
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> ##1 !$rose(out_valid))
		else $error("result produced too early");

	// the block is free to take a request whenever a new result shows up
	a_free_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result shown while still busy");

	// a stalled result stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result dropped or changed");

	// the user makes register writes only while no request is in progress
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |-> !in_stall)
		else $error("register written while busy");

endmodule

bind fuzzy_self_tuning_pid fstp_check u_fstp_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.out_data  (out_data)
);

@@ bench/fstp_checker.sv @@
// Checker for the fuzzy self-tuning PID: watches the request, result and
// register channels, predicts each result and compares it. Needs fstp_pkg.
module fstp_checker
	import fstp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_item_t out_data,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data,
	output int        failures,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint MU_ONE = 64'sd65536;

	out_item_t expected_q[$];
	longint    err_z1, err_z2, kp_g, ki_g, kd_g;

	function automatic longint ramp(longint num, int span);
		return (num * MU_ONE) / (longint'(span) * 256);
	endfunction

	function automatic longint tri_mu(longint x, int a, int b, int c);
		if (x <= a * 256) return 0;
		if (x <= b * 256) return ramp(x - a * 256, b - a);
		if (x <= c * 256) return ramp(c * 256 - x, c - b);
		return 0;
	endfunction

	// membership of x in set k (NB..PB)
	function automatic longint memb(longint x, int k);
		case (k)
			0: begin
				if (x <= -768) return MU_ONE;
				if (x <= -256) return ramp(-256 - x, 2);
				return 0;
			end
			1: return tri_mu(x, -3, -2, 0);
			2: return tri_mu(x, -3, -1, 1);
			3: return tri_mu(x, -2, 0, 2);
			4: return tri_mu(x, -1, 1, 3);
			5: return tri_mu(x, 0, 2, 3);
			default: begin
				if (x <= 256) return 0;
				if (x < 768) return ramp(x - 256, 2);
				return MU_ONE;
			end
		endcase
	endfunction

	function automatic longint gain_delta(int a, int b, longint mu, int units);
		longint num, den;
		num = (longint'(a) * MU_ONE + longint'(b) * mu) * 65536;
		den = 2 * MU_ONE * units;
		if (num >= 0) return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// one control step: tune the gains, then form the PID increment
	function out_item_t tune_and_step(in_item_t req);
		longint    e, ec, s, best, acc, lim;
		int        bi, bj, cp, ci, cd, bd;
		out_item_t r;
		e = longint'(req.setpoint) - longint'(req.feedback);
		ec = e - err_z1;
		best = -1; bi = 0; bj = 0;
		for (int i = 0; i < NUM_SETS; i++)
			for (int j = 0; j < NUM_SETS; j++) begin
				s = memb(e, i) < memb(ec, j) ? memb(e, i) : memb(ec, j);
				if (s > best) begin
					best = s; bi = i; bj = j;
				end
			end
		cp = KP_TAB[bi][bj];
		ci = KI_TAB[bi][bj];
		cd = KD_TAB[bi][bj];
		bd = (cd == CODE_NS) ? 4 : int'(SET_B[cd]);  // odd Kd NS slope
		kp_g = sat32(kp_g + gain_delta(SET_A[cp], SET_B[cp], best, KP_UNITS));
		ki_g = sat32(ki_g + gain_delta(SET_A[ci], SET_B[ci], best, KI_UNITS));
		kd_g = sat32(kd_g + gain_delta(SET_A[cd], bd, best, KD_UNITS));
		acc = kp_g * (e - err_z1) + ki_g * e + kd_g * (e - 2 * err_z1 + err_z2);
		acc = (acc + 128) >>> 8;  // ties toward plus infinity
		lim = (64'sd1 <<< 39) - 1;
		if (acc > lim) acc = lim;
		if (acc < -lim - 1) acc = -lim - 1;
		err_z2 = err_z1;
		err_z1 = e;
		r.drive_increment = acc[39:0];
		r.kp_now = kp_g[31:0];
		r.ki_now = ki_g[31:0];
		r.kd_now = kd_g[31:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			err_z1 <= 0; err_z2 <= 0;
			kp_g <= longint'(KP_RESET); ki_g <= longint'(KI_RESET); kd_g <= longint'(KD_RESET);
			failures <= 0;
			pending <= 0;
			expected_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KP_START: kp_g = longint'(signed'(cfg_data));
					REG_KI_START: ki_g = longint'(signed'(cfg_data));
					REG_KD_START: kd_g = longint'(signed'(cfg_data));
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_q.push_back(tune_and_step(in_data));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					if (failures < 10)
						$display("unexpected result %h", out_data);
					failures <= failures + 1;
				end else begin
					want = expected_q.pop_front();
					if (want !== out_data) begin
						if (failures < 10)
							$display("result differs: exp inc=%0d kp=%0d ki=%0d kd=%0d, got inc=%0d kp=%0d ki=%0d kd=%0d",
								want.drive_increment, want.kp_now, want.ki_now, want.kd_now,
								out_data.drive_increment, out_data.kp_now, out_data.ki_now,
								out_data.kd_now);
						failures <= failures + 1;
					end
				end
			end
			pending <= expected_q.size();
		end
	end
endmodule

@@ bench/tb.sv @@
// Stimulus and verdict for the fuzzy self-tuning PID testbench.
// Depends on fstp_pkg, fuzzy_self_tuning_pid and fstp_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fstp_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int         failures, pending;
	int         sent = 0;
	bit         calm = 1'b0;

	fuzzy_self_tuning_pid u_dut (.*);

	fstp_checker u_chk (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("fuzzy_self_tuning_pid: mismatch");
		$finish;
	end

	// result side: random stall, one long hold-off to back the block up
	initial begin
		int hold;
		bit held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && sent >= 400) begin
				held = 1'b1;
				hold = 300;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else
				out_stall <= !calm && ($urandom_range(99) < 18);
		end
	end

	task automatic send(input logic [15:0] sp, input logic [15:0] fb);
		if (!calm && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{setpoint: sp, feedback: fb};
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [15:0] near_value();
		// mostly within a few real units so every fuzzy set gets exercised
		if ($urandom_range(3) == 0) return 16'($urandom);
		return 16'($signed($urandom_range(0, 2047)) - 1024);
	endfunction

	initial begin
		logic [31:0] kp_set [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000};
		logic [31:0] ki_set [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0000_4000};
		logic [31:0] kd_set [4] = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_8000};
		logic [15:0] edge_sp [12] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0300, 16'hFD00,
			16'h0200, 16'hFE00, 16'h0100, 16'hFF00, 16'h0000, 16'h7FFF, 16'h8000};
		logic [15:0] edge_fb [12] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains first, with the extremes of the samples and set breakpoints
		for (int i = 0; i < 12; i++) send(edge_sp[i], edge_fb[i]);
		for (int k = -3; k <= 3; k++) send(16'(k * 256 + 1), 16'h0000);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			if (ph < 4) begin
				write_reg(REG_KP_START, kp_set[ph]);
				write_reg(REG_KI_START, ki_set[ph]);
				write_reg(REG_KD_START, kd_set[ph]);
			end else begin
				write_reg(REG_KP_START, $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 1 << 19));
				write_reg(REG_KI_START, $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 1 << 17));
				write_reg(REG_KD_START, $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 1 << 17));
			end
			write_reg(2'd3, $urandom);  // unused index, must be ignored
			cfg_valid <= 1'b0;
			calm = (ph == 5);
			for (int n = 0; n < 148; n++) send(near_value(), near_value());
			drain();
		end

		if (failures == 0 && pending == 0)
			$display("fuzzy_self_tuning_pid: match");
		else
			$display("fuzzy_self_tuning_pid: mismatch");
		$finish;
	end
endmodule
